>>> src/cartesian_polar_converter_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

// Check that cond implies result at every clock edge outside reset.
`define CPC_ASSERT_IMPLY(label, clk, rst_n, cond, result) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error("converter implication check failed");

// Check that a condition never holds outside reset.
`define CPC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("converter forbidden condition seen");

`endif

>>> src/cpc_pkg.sv
// Shared types and constants of the Cartesian/polar converter.
`timescale 1ns / 1ps
package cpc_pkg;

    // Internal CORDIC word: Q15.16 plus 16 guard bits plus growth headroom
    localparam int CW = 52;

    localparam logic [31:0] GAIN_Q32  = 32'h9B74EDA8;
    localparam logic [31:0] ANGLE_PI  = 32'h80000000;

    localparam logic [1:0] OP_TO_POLAR = 2'd0;
    localparam logic [1:0] OP_TO_CART  = 2'd1;
    localparam logic [1:0] OP_MOVE     = 2'd2;

    // atan(2^-i) in binary-angle units
    localparam logic [31:0] ATAN_TAB [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Sideband that rides along the rotating CORDIC
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
    } rot_side_t;

    // Sideband that rides along the vectoring CORDIC
    typedef struct packed {
        logic [1:0]         op;
        logic               flag;
        logic               origin;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
    } vec_side_t;

endpackage

>>> src/cartesian_polar_converter.sv
// Top level of the pipelined Cartesian/polar converter.
//
//   channel  | handshake      | fields
//   ---------+----------------+-------------------------------------------------
//   command  | start / busy   | opcode coord_x coord_y radius angle shift_x shift_y
//   result   | done (strobe)  | out_x out_y out_radius out_angle saturated
//
// The pipeline registers are, in order: the input register with the gain
// multiply, one stage per rotating micro-rotation, round, shift add, one stage
// per vectoring micro-rotation, split gain multiply, output register.
// One beat is taken every cycle; busy stays low since results are never held.
// Reset clears the valid bits only; the data path carries no state.
`timescale 1ns / 1ps
`include "cartesian_polar_converter_assert.svh"
module cartesian_polar_converter #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [31:0]        radius,
    input  logic signed [31:0] angle,
    input  logic signed [31:0] shift_x,
    input  logic signed [31:0] shift_y,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic [31:0]        out_radius,
    output logic signed [31:0] out_angle,
    output logic               saturated
);

    localparam int CW      = cpc_pkg::CW;
    localparam int ROT_W   = $bits(cpc_pkg::rot_side_t);
    localparam int VEC_W   = $bits(cpc_pkg::vec_side_t);
    localparam int LATENCY = 2 * CORDIC_STEPS + 5;

    assign busy = 1'b0;

    // ---------------- input stage: gain premultiply ----------------
    logic                v0_reg;
    logic [63:0]         prod0_reg;
    logic [31:0]         ang0_reg;
    cpc_pkg::rot_side_t  side0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        prod0_reg         <= 64'(radius) * 64'(cpc_pkg::GAIN_Q32);
        ang0_reg          <= angle;
        side0_reg.op      <= opcode;
        side0_reg.coord_x <= coord_x;
        side0_reg.coord_y <= coord_y;
        side0_reg.shift_x <= shift_x;
        side0_reg.shift_y <= shift_y;
    end

    // Fold the left half plane onto the right one
    logic                 rot_fold;
    logic signed [CW-1:0] rot_x_in;
    logic [31:0]          rot_z_in;

    always_comb
    begin
        rot_fold = ang0_reg[31] ^ ang0_reg[30];
        rot_x_in = CW'(prod0_reg[63:16]);
        rot_z_in = ang0_reg;
        if (rot_fold)
        begin
            rot_x_in = -rot_x_in;
            rot_z_in = ang0_reg ^ cpc_pkg::ANGLE_PI;
        end
    end

    logic                 rot_v;
    logic signed [CW-1:0] rot_x;
    logic signed [CW-1:0] rot_y;
    logic [31:0]          rot_z;
    logic [ROT_W-1:0]     rot_side_raw;

    cpc_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .SIDE_W(ROT_W)) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_x      (rot_x_in),
        .in_y      ('0),
        .in_z      (rot_z_in),
        .in_side   (side0_reg),
        .out_valid (rot_v),
        .out_x     (rot_x),
        .out_y     (rot_y),
        .out_z     (rot_z),
        .out_side  (rot_side_raw)
    );

    cpc_pkg::rot_side_t rot_side;
    assign rot_side = rot_side_raw;

    // ---------------- round and clamp the Cartesian point ----------------
    logic signed [CW-1:0]    rx_sum;
    logic signed [CW-1:0]    ry_sum;
    logic signed [CW-17:0]   rx_rnd;
    logic signed [CW-17:0]   ry_rnd;
    logic signed [31:0]      rx_sat;
    logic signed [31:0]      ry_sat;
    logic                    rx_ovf;
    logic                    ry_ovf;

    always_comb
    begin
        rx_sum = rot_x + CW'(32768);
        ry_sum = rot_y + CW'(32768);
        rx_rnd = rx_sum[CW-1:16];
        ry_rnd = ry_sum[CW-1:16];
        rx_ovf = (rx_rnd > (CW-16)'(64'sh7FFFFFFF)) || (rx_rnd < -(CW-16)'(64'sh80000000));
        ry_ovf = (ry_rnd > (CW-16)'(64'sh7FFFFFFF)) || (ry_rnd < -(CW-16)'(64'sh80000000));
        rx_sat = rx_ovf ? (rx_rnd[CW-17] ? 32'sh80000000 : 32'sh7FFFFFFF) : rx_rnd[31:0];
        ry_sat = ry_ovf ? (ry_rnd[CW-17] ? 32'sh80000000 : 32'sh7FFFFFFF) : ry_rnd[31:0];
    end

    logic                v1_reg;
    logic signed [31:0]  px1_reg;
    logic signed [31:0]  py1_reg;
    logic                flag1_reg;
    cpc_pkg::rot_side_t  side1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= rot_v;
    end

    always_ff @(posedge clk)
    begin
        px1_reg   <= rx_sat;
        py1_reg   <= ry_sat;
        flag1_reg <= (rx_ovf || ry_ovf) &&
                     (rot_side.op == cpc_pkg::OP_TO_CART || rot_side.op == cpc_pkg::OP_MOVE);
        side1_reg <= rot_side;
    end

    // ---------------- add the pole shift ----------------
    logic signed [32:0] sx_sum;
    logic signed [32:0] sy_sum;
    logic               sx_ovf;
    logic               sy_ovf;

    always_comb
    begin
        sx_sum = 33'(px1_reg) + 33'(side1_reg.shift_x);
        sy_sum = 33'(py1_reg) + 33'(side1_reg.shift_y);
        sx_ovf = sx_sum[32] != sx_sum[31];
        sy_ovf = sy_sum[32] != sy_sum[31];
    end

    logic                v2_reg;
    logic signed [31:0]  cx2_reg;
    logic signed [31:0]  cy2_reg;
    logic signed [31:0]  ox2_reg;
    logic signed [31:0]  oy2_reg;
    logic                flag2_reg;
    logic [1:0]          op2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    // Hold the vectoring source: raw point or shifted point
    always_ff @(posedge clk)
    begin
        op2_reg <= side1_reg.op;
        ox2_reg <= px1_reg;
        oy2_reg <= py1_reg;
        if (side1_reg.op == cpc_pkg::OP_MOVE)
        begin
            cx2_reg   <= sx_ovf ? (sx_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : sx_sum[31:0];
            cy2_reg   <= sy_ovf ? (sy_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : sy_sum[31:0];
            flag2_reg <= flag1_reg || sx_ovf || sy_ovf;
        end
        else
        begin
            cx2_reg   <= side1_reg.coord_x;
            cy2_reg   <= side1_reg.coord_y;
            flag2_reg <= flag1_reg;
        end
    end

    // Scale to guard bits and fold negative x
    logic signed [CW-1:0] vec_x_in;
    logic signed [CW-1:0] vec_y_in;
    logic [31:0]          vec_z_in;
    cpc_pkg::vec_side_t   vec_side_in;

    always_comb
    begin
        vec_x_in = CW'($signed({cx2_reg, 16'h0000}));
        vec_y_in = CW'($signed({cy2_reg, 16'h0000}));
        vec_z_in = '0;
        if (cx2_reg[31])
        begin
            vec_x_in = -vec_x_in;
            vec_y_in = -vec_y_in;
            vec_z_in = cpc_pkg::ANGLE_PI;
        end
        vec_side_in.op     = op2_reg;
        vec_side_in.flag   = flag2_reg;
        vec_side_in.origin = (cx2_reg == '0) && (cy2_reg == '0);
        vec_side_in.ox     = ox2_reg;
        vec_side_in.oy     = oy2_reg;
    end

    logic                 vec_v;
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic [31:0]          vec_z;
    logic [VEC_W-1:0]     vec_side_raw;

    cpc_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .SIDE_W(VEC_W)) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_x      (vec_x_in),
        .in_y      (vec_y_in),
        .in_z      (vec_z_in),
        .in_side   (vec_side_in),
        .out_valid (vec_v),
        .out_x     (vec_x),
        .out_y     (vec_y),
        .out_z     (vec_z),
        .out_side  (vec_side_raw)
    );

    // ---------------- gain correction, split multiply ----------------
    logic [CW-1:0] mag_u;
    assign mag_u = vec_x[CW-1] ? '0 : vec_x;

    logic                v3_reg;
    logic [CW-1:0]       phi3_reg;
    logic [31:0]         plo3_reg;
    logic [31:0]         ang3_reg;
    cpc_pkg::vec_side_t  side3_reg;
    logic [63:0]         plo_full;

    assign plo_full = 64'(mag_u[31:0]) * 64'(cpc_pkg::GAIN_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= vec_v;
    end

    always_ff @(posedge clk)
    begin
        phi3_reg  <= CW'(mag_u[CW-1:32] * CW'(cpc_pkg::GAIN_Q32));
        plo3_reg  <= plo_full[63:32];
        ang3_reg  <= vec_z;
        side3_reg <= vec_side_raw;
    end

    // ---------------- round, clamp and drive the result ----------------
    logic [CW+1:0] mag_sum;
    logic [CW-15:0] mag_rnd;
    logic          mag_ovf;
    logic          polar_op;
    logic          polar_live;

    always_comb
    begin
        mag_sum    = (CW+2)'(phi3_reg) + (CW+2)'(plo3_reg) + (CW+2)'(32768);
        mag_rnd    = mag_sum[CW+1:16];
        mag_ovf    = mag_rnd[CW-15:32] != '0;
        polar_op   = (side3_reg.op == cpc_pkg::OP_TO_POLAR) || (side3_reg.op == cpc_pkg::OP_MOVE);
        polar_live = polar_op && !side3_reg.origin;
    end

    logic               done_reg;
    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic [31:0]        out_radius_reg;
    logic signed [31:0] out_angle_reg;
    logic               saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        out_x_reg      <= (side3_reg.op == cpc_pkg::OP_TO_CART) ? side3_reg.ox : '0;
        out_y_reg      <= (side3_reg.op == cpc_pkg::OP_TO_CART) ? side3_reg.oy : '0;
        out_radius_reg <= polar_live ? (mag_ovf ? 32'hFFFFFFFF : mag_rnd[31:0]) : '0;
        out_angle_reg  <= polar_live ? ang3_reg : '0;
        saturated_reg  <= side3_reg.flag || (polar_live && mag_ovf);
    end

    assign done       = done_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_radius = out_radius_reg;
    assign out_angle  = out_angle_reg;
    assign saturated  = saturated_reg;

    // ---------------- checks ----------------
    `CPC_ASSERT_IMPLY(a_done_latency, clk, rst_n, done, $past(start, LATENCY))
    `CPC_ASSERT_IMPLY(a_one_form, clk, rst_n, done, (out_x == 0 && out_y == 0) || (out_radius == 0 && out_angle == 0))
    `CPC_ASSERT_NEVER(a_no_busy, clk, rst_n, busy)

endmodule

>>> src/cpc_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, rotate or vector mode.
`timescale 1ns / 1ps
module cpc_cordic #(
    parameter int STEPS  = 24,
    parameter bit VECTOR = 1'b0,
    parameter int SIDE_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [cpc_pkg::CW-1:0] in_x,
    input  logic signed [cpc_pkg::CW-1:0] in_y,
    input  logic [31:0]                  in_z,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic signed [cpc_pkg::CW-1:0] out_x,
    output logic signed [cpc_pkg::CW-1:0] out_y,
    output logic [31:0]                  out_z,
    output logic [SIDE_W-1:0]            out_side
);

    // Stage taps: entry i is what stage i works on
    logic                          valid_s [0:STEPS];
    logic signed [cpc_pkg::CW-1:0] x_s     [0:STEPS];
    logic signed [cpc_pkg::CW-1:0] y_s     [0:STEPS];
    logic [31:0]                   z_s     [0:STEPS];
    logic [SIDE_W-1:0]             side_s  [0:STEPS];

    // Stage zero is the input itself
    assign valid_s[0] = in_valid;
    assign x_s[0]     = in_x;
    assign y_s[0]     = in_y;
    assign z_s[0]     = in_z;
    assign side_s[0]  = in_side;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic signed [cpc_pkg::CW-1:0] dx;
        logic signed [cpc_pkg::CW-1:0] dy;
        logic                          up;
        logic signed [cpc_pkg::CW-1:0] x_next;
        logic signed [cpc_pkg::CW-1:0] y_next;
        logic [31:0]                   z_next;
        logic                          valid_reg;
        logic signed [cpc_pkg::CW-1:0] x_reg;
        logic signed [cpc_pkg::CW-1:0] y_reg;
        logic [31:0]                   z_reg;
        logic [SIDE_W-1:0]             side_reg;

        // Pick the turn direction and apply one micro-rotation
        always_comb
        begin
            dx = y_s[i] >>> i;
            dy = x_s[i] >>> i;
            up = VECTOR ? !y_s[i][cpc_pkg::CW-1] : z_s[i][31];
            if (up)
            begin
                x_next = x_s[i] + dx;
                y_next = y_s[i] - dy;
                z_next = z_s[i] + cpc_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_next = x_s[i] - dx;
                y_next = y_s[i] + dy;
                z_next = z_s[i] - cpc_pkg::ATAN_TAB[i];
            end
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= valid_s[i];
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_s[i];
        end

        assign valid_s[i+1] = valid_reg;
        assign x_s[i+1]     = x_reg;
        assign y_s[i+1]     = y_reg;
        assign z_s[i+1]     = z_reg;
        assign side_s[i+1]  = side_reg;
    end

    assign out_valid = valid_s[STEPS];
    assign out_x     = x_s[STEPS];
    assign out_y     = y_s[STEPS];
    assign out_z     = z_s[STEPS];
    assign out_side  = side_s[STEPS];

endmodule
